@@ hdl/nsa_pkg.sv @@
// Shared types and constants for the NFA string acceptor.
// Used by the front, queue, back and top-level modules; depends on nothing.
`default_nettype none

package nsa_pkg;

  localparam int unsigned STATE_IDX_W = 3;
  localparam int unsigned SYM_W       = 8;
  localparam int unsigned MASK_W      = 8;
  localparam int unsigned REQ_W       = 2;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SYM  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_END  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FINAL_MASK  = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_SYM  = 2'd1,
    OP_END  = 2'd2
  } op_kind_e;

  typedef struct packed {
    op_kind_e               kind;
    logic [STATE_IDX_W-1:0] from_state;
    logic [SYM_W-1:0]       symbol;
    logic [MASK_W-1:0]      target_mask;
    logic                   last;
    logic                   sym_ok;
  } op_t;

  typedef struct packed {
    logic [STATE_IDX_W-1:0] start_state;
    logic [MASK_W-1:0]      final_mask;
  } cfg_t;

endpackage

`default_nettype wire

@@ hdl/nsa_front.sv @@
// Front end: accepts input items and classifies them into queue operations.
// Depends on nsa_pkg; drops unused requests and out-of-range loads.
`default_nettype none

module nsa_front #(
  parameter int unsigned NUM_STATES  = 8,
  parameter int unsigned NUM_SYMBOLS = 256
) (
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [nsa_pkg::REQ_W-1:0]       req_type_i,
  input  wire logic [nsa_pkg::STATE_IDX_W-1:0] from_state_i,
  input  wire logic [nsa_pkg::SYM_W-1:0]       symbol_i,
  input  wire logic [nsa_pkg::MASK_W-1:0]      target_mask_i,
  input  wire logic                            last_i,
  input  wire logic                            full_i,
  output logic                                 push_o,
  output nsa_pkg::op_t                         op_o
);
  import nsa_pkg::*;

  logic from_ok;
  logic sym_ok;
  logic keep;

  assign from_ok = ({1'b0, from_state_i} < (STATE_IDX_W + 1)'(NUM_STATES));
  assign sym_ok  = ({1'b0, symbol_i} < (SYM_W + 1)'(NUM_SYMBOLS));

  always_comb begin
    op_o.kind        = OP_END;
    op_o.from_state  = from_state_i;
    op_o.symbol      = symbol_i;
    op_o.target_mask = target_mask_i;
    op_o.last        = last_i;
    op_o.sym_ok      = sym_ok;
    keep             = 1'b0;
    case (req_type_i)
      REQ_LOAD: begin
        op_o.kind = OP_LOAD;
        keep      = from_ok && sym_ok;
      end
      REQ_SYM: begin
        op_o.kind = OP_SYM;
        keep      = 1'b1;
      end
      REQ_END: begin
        op_o.kind = OP_END;
        keep      = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i && keep;

endmodule

`default_nettype wire

@@ hdl/nsa_fifo.sv @@
// Short queue of classified operations between the front and the back.
// Depends on nsa_pkg for the operation type and the queue depth.
`default_nettype none

module nsa_fifo (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire nsa_pkg::op_t wdata_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic              valid_o,
  output nsa_pkg::op_t      rdata_o
);
  import nsa_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  op_t              entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   count_q, count_d;

  assign full_o  = (count_q == (PTR_W + 1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

@@ hdl/nsa_back.sv @@
// Back end: transition store, active-set update and the result register.
// Depends on nsa_pkg; reads operations from the queue in order.
`default_nettype none

module nsa_back #(
  parameter int unsigned NUM_STATES  = 8,
  parameter int unsigned NUM_SYMBOLS = 256
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire nsa_pkg::cfg_t cfg_i,
  input  wire logic          head_vld_i,
  input  wire nsa_pkg::op_t  head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic               accepted_o,
  output logic               died_o
);
  import nsa_pkg::*;

  localparam int unsigned ST_W  = $clog2(NUM_STATES);
  localparam int unsigned ADR_W = $clog2(NUM_SYMBOLS);
  localparam int unsigned ROW_W = NUM_STATES * NUM_STATES;

  logic [ROW_W-1:0]      mem_q [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0] row_vld_q;
  logic [ROW_W-1:0]      rd_row_q;
  logic                  rd_vld_q;

  logic                  b_vld_q;
  op_kind_e              b_kind_q;
  logic                  b_last_q;

  logic [NUM_STATES-1:0] active_q, active_d;
  logic                  fresh_q, fresh_d;
  logic                  out_vld_q, out_vld_d;
  logic                  accepted_q, accepted_d;
  logic                  died_q, died_d;

  logic                  adv;
  logic                  wr_en;
  logic                  rd_en;
  logic [ADR_W-1:0]      addr;
  logic [ST_W-1:0]       wr_lane;
  logic [NUM_STATES-1:0] wr_mask;
  logic                  wr_full;
  logic                  start_ok;
  logic [NUM_STATES-1:0] start_set;
  logic [NUM_STATES-1:0] cur_set;
  logic [NUM_STATES-1:0] next_set;
  logic [NUM_STATES-1:0] res_set;
  logic [ROW_W-1:0]      row;

  assign adv     = !out_vld_q || !out_stall_i;
  assign pop_o   = adv && head_vld_i;
  assign wr_en   = pop_o && (head_i.kind == OP_LOAD);
  assign rd_en   = pop_o && (head_i.kind == OP_SYM);
  assign addr    = head_i.symbol[ADR_W-1:0];
  assign wr_lane = head_i.from_state[ST_W-1:0];
  assign wr_mask = head_i.target_mask[NUM_STATES-1:0];
  assign wr_full = !row_vld_q[addr];

  // A row that was never loaded reads as all zero; its first load clears the other lanes.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      for (int l = 0; l < NUM_STATES; l++) begin
        if (wr_full || (l == int'(wr_lane))) begin
          mem_q[addr][l*NUM_STATES +: NUM_STATES] <=
            (l == int'(wr_lane)) ? wr_mask : '0;
        end
      end
    end
    if (rd_en) begin
      rd_row_q <= mem_q[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_q[addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= head_i.sym_ok && row_vld_q[addr];
      end
    end
  end

  assign start_ok  = ({1'b0, cfg_i.start_state} < (STATE_IDX_W + 1)'(NUM_STATES));
  assign start_set = start_ok ? (NUM_STATES'(1) << cfg_i.start_state) : '0;
  assign cur_set   = fresh_q ? start_set : active_q;
  assign row       = rd_vld_q ? rd_row_q : '0;

  always_comb begin
    next_set = '0;
    for (int l = 0; l < NUM_STATES; l++) begin
      if (cur_set[l]) begin
        next_set = next_set | row[l*NUM_STATES +: NUM_STATES];
      end
    end
  end

  always_comb begin
    active_d   = active_q;
    fresh_d    = fresh_q;
    out_vld_d  = out_vld_q;
    accepted_d = accepted_q;
    died_d     = died_q;
    res_set    = cur_set;
    if (adv) begin
      out_vld_d = 1'b0;
      if (b_vld_q) begin
        case (b_kind_q)
          OP_SYM: begin
            active_d = next_set;
            fresh_d  = 1'b0;
            res_set  = next_set;
            if (b_last_q) begin
              out_vld_d = 1'b1;
              active_d  = '0;
              fresh_d   = 1'b1;
            end
          end
          OP_END: begin
            out_vld_d = 1'b1;
            active_d  = '0;
            fresh_d   = 1'b1;
          end
          default: begin
            out_vld_d = 1'b0;
          end
        endcase
        if (out_vld_d) begin
          accepted_d = |(res_set & cfg_i.final_mask[NUM_STATES-1:0]);
          died_d     = (res_set == '0);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q   <= 1'b0;
      active_q  <= '0;
      fresh_q   <= 1'b1;
      out_vld_q <= 1'b0;
    end else begin
      if (adv) begin
        b_vld_q <= head_vld_i;
      end
      active_q  <= active_d;
      fresh_q   <= fresh_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_kind_q <= head_i.kind;
      b_last_q <= head_i.last;
    end
    accepted_q <= accepted_d;
    died_q     <= died_d;
  end

  assign out_valid_o = out_vld_q;
  assign accepted_o  = accepted_q;
  assign died_o      = died_q;

endmodule

`default_nettype wire

@@ hdl/nfa_string_acceptor.sv @@
// NFA string acceptor: bit-parallel simulation of an automaton over a byte stream.
// Throughput: one item per cycle while the output is not stalled; the queue pop with
// the registered row read of the transition store and the active-set update on that
// row overlap. Reset: the transition store reads as empty through per-row valid flags,
// with no clearing pass; the active set restarts at the start state; the valid flags,
// active set and configuration registers return to zero.
`default_nettype none

module nfa_string_acceptor #(
  parameter int unsigned NUM_STATES  = 8,
  parameter int unsigned NUM_SYMBOLS = 256
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [nsa_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [nsa_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [nsa_pkg::REQ_W-1:0]        req_type_i,
  input  wire logic [nsa_pkg::STATE_IDX_W-1:0]  from_state_i,
  input  wire logic [nsa_pkg::SYM_W-1:0]        symbol_i,
  input  wire logic [nsa_pkg::MASK_W-1:0]       target_mask_i,
  input  wire logic                             last_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic                                  accepted_o,
  output logic                                  died_o
);
  import nsa_pkg::*;

  cfg_t cfg_q, cfg_d;
  op_t  push_op;
  op_t  head_op;
  logic push;
  logic pop;
  logic fifo_full;
  logic fifo_vld;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_STATE: cfg_d.start_state = cfg_data_i[STATE_IDX_W-1:0];
        CFG_FINAL_MASK:  cfg_d.final_mask  = cfg_data_i[MASK_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  nsa_front #(
    .NUM_STATES  (NUM_STATES),
    .NUM_SYMBOLS (NUM_SYMBOLS)
  ) u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .from_state_i  (from_state_i),
    .symbol_i      (symbol_i),
    .target_mask_i (target_mask_i),
    .last_i        (last_i),
    .full_i        (fifo_full),
    .push_o        (push),
    .op_o          (push_op)
  );

  nsa_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_op),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .valid_o (fifo_vld),
    .rdata_o (head_op)
  );

  nsa_back #(
    .NUM_STATES  (NUM_STATES),
    .NUM_SYMBOLS (NUM_SYMBOLS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_vld_i  (fifo_vld),
    .head_i      (head_op),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .accepted_o  (accepted_o),
    .died_o      (died_o)
  );

  // The front must hold off the input whenever the queue has no free entry.
  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_full |-> in_stall_o)
    else $error("queue full but input not stalled");

  // The back only takes an operation that the queue actually holds.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> fifo_vld)
    else $error("operation taken from an empty queue");

  // A transfer into a full queue would overwrite a pending operation.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_full && !pop |=> !fifo_vld || (head_op == $past(head_op)))
    else $error("queue head changed without a pop");

endmodule

`default_nettype wire
